// ===== design/bart_pkg.sv =====
`default_nettype none
package bart_pkg;
  localparam int MaxDevices = 16;
  localparam int NameLen = 16;
  localparam int SlotW = (MaxDevices > 1) ? $clog2(MaxDevices) : 1;
  localparam int TotW = $clog2(MaxDevices + 1);
  localparam int NameW = $clog2(NameLen);
  localparam int KeyW = 56;
  localparam logic [7:0] TypeTxPower = 8'h0A;
  localparam logic [7:0] TypeNameFull = 8'h09;
  localparam logic [7:0] TypeNameShort = 8'h08;
  localparam logic [0:0] RegDefaultPower = 1'b0;
  localparam logic [0:0] RegLossTwoM = 1'b1;

  typedef struct packed {
    logic start;
    logic [KeyW-1:0] key;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic full;
    logic [SlotW-1:0] slot;
  } srch_rsp_t;

  function automatic logic [10:0] dist_of(input logic signed [9:0] loss);
    logic [10:0] d;
    if (loss <= 0) d = 11'd100;
    else if (loss <= 6) d = 11'd201;
    else if (loss <= 10) d = 11'd316;
    else if (loss <= 14) d = 11'd500;
    else if (loss <= 20) d = 11'd1000;
    else d = 11'd2000;
    return d;
  endfunction
endpackage
`default_nettype wire

// ===== design/bart_ram.sv =====
`default_nettype none
module bart_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/bart_search.sv =====
`default_nettype none
module bart_search import bart_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire srch_req_t req,
  output srch_rsp_t rsp
);
  typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_DONE} st_t;
  st_t st_r;
  logic [TotW-1:0] total_r, idx_r;
  logic [KeyW-1:0] key_r, rdata;
  logic full_r;
  logic [SlotW-1:0] slot_r;
  logic we;

  assign we = (st_r == S_CMP) && (idx_r == total_r) && (total_r < TotW'(MaxDevices));

  bart_ram #(.Width(KeyW), .Depth(1 << SlotW)) u_ram (
    .clk(clk), .we(we), .waddr(idx_r[SlotW-1:0]), .wdata(key_r),
    .raddr(idx_r[SlotW-1:0]), .rdata(rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      total_r <= '0;
      idx_r <= '0;
      full_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (req.start) begin
          key_r <= req.key;
          idx_r <= '0;
          st_r <= S_READ;
        end
        S_READ: st_r <= S_CMP;
        S_CMP: begin
          // Every comparison uses the one registered RAM read port.
          if (idx_r == total_r) begin
            full_r <= (total_r >= TotW'(MaxDevices));
            slot_r <= idx_r[SlotW-1:0];
            if (total_r < TotW'(MaxDevices)) total_r <= total_r + 1'b1;
            st_r <= S_DONE;
          end else if (rdata == key_r) begin
            full_r <= 1'b0;
            slot_r <= idx_r[SlotW-1:0];
            st_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r <= S_READ;
          end
        end
        S_DONE: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = (st_r == S_DONE);
  assign rsp.full = full_r;
  assign rsp.slot = slot_r;

`ifndef SYNTHESIS
  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TotW'(MaxDevices)) else $error("device count overflow");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= total_r) else $error("search index past total");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done) else $error("done held");
`endif
endmodule
`default_nettype wire

// ===== design/ble_adv_range_tracker_core.sv =====
`default_nettype none
// BLE advertisement range tracker. Payload bytes are taken one item per cycle
// while in_stall is low and parsed as they arrive. On the item with last_byte set
// the block looks the advertiser up in a 16-entry address table by walking it
// entry by entry through a single RAM read port, then emits NAME_LEN-1 result
// items (or one item with status set when the table is full). in_stall is high
// throughout the search and the emission of the results.
module ble_adv_range_tracker_core import bart_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [47:0] in_peer_address,
  input  wire logic [7:0] in_peer_address_type,
  input  wire logic signed [7:0] in_rssi,
  input  wire logic [7:0] in_payload_byte,
  input  wire logic in_byte_valid,
  input  wire logic in_last_byte,
  output logic out_valid,
  input  wire logic out_stall,
  output logic out_status,
  output logic [3:0] out_slot,
  output logic signed [7:0] out_power_used,
  output logic [10:0] out_distance_cm,
  output logic out_near,
  output logic [3:0] out_char_index,
  output logic [7:0] out_name_char,
  output logic out_run_last,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  typedef enum logic [1:0] {P_LEN, P_TYPE, P_VAL} ph_t;
  typedef enum logic [1:0] {M_PARSE, M_SEARCH, M_EMIT} md_t;

  md_t md_r;
  ph_t ph_r;
  logic [7:0] dflt_r, loss2_r;
  logic [8:0] pos_r, send_r;
  logic [7:0] kind_r, pend_r, chosen_r, flen_r;
  logic halted_r, pfound_r, ntaken_r, vcnt0_r;
  logic [7:0] name_r [NameLen-1];
  logic [NameW-1:0] nlen_r, k_r;
  logic signed [7:0] rssi_r, pwr_r;
  logic [10:0] dist_r;
  logic near_r, full_r;
  logic [SlotW-1:0] slot_r;
  srch_req_t req;
  srch_rsp_t rsp;
  logic take, acc;
  logic is_name;

  assign cfg_ready = 1'b1;
  assign in_stall = (md_r != M_PARSE);
  assign acc = in_valid && !in_stall;
  assign take = acc && in_byte_valid && !halted_r && !pos_r[8];
  assign is_name = (kind_r == TypeNameFull) || (kind_r == TypeNameShort);
  assign req.start = acc && in_last_byte;
  assign req.key = {in_peer_address_type, in_peer_address};

  bart_search u_search (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  always_ff @(posedge clk) begin
    logic [8:0] npos;
    logic done_s;
    logic signed [9:0] pw, rs;
    npos = pos_r + 9'd1;
    done_s = 1'b0;
    if (!rst_n) begin
      md_r <= M_PARSE;
      ph_r <= P_LEN;
      dflt_r <= 8'd0;
      loss2_r <= 8'd46;
      pos_r <= '0; send_r <= '0; kind_r <= '0; pend_r <= '0; chosen_r <= '0;
      flen_r <= '0; halted_r <= 1'b0; pfound_r <= 1'b0; ntaken_r <= 1'b0;
      vcnt0_r <= 1'b1; nlen_r <= '0; k_r <= '0; out_valid <= 1'b0;
      for (int i = 0; i < NameLen - 1; i++) name_r[i] <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          RegDefaultPower: dflt_r <= cfg_data;
          RegLossTwoM: loss2_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (md_r)
        M_PARSE: begin
          if (take) begin
            pos_r <= npos;
            unique case (ph_r)
              P_LEN: begin
                if (in_payload_byte == 8'd0) halted_r <= 1'b1;
                else begin
                  flen_r <= in_payload_byte;
                  send_r <= pos_r + {1'b0, in_payload_byte} + 9'd1;
                  vcnt0_r <= 1'b1;
                  ph_r <= P_TYPE;
                end
              end
              P_TYPE: begin
                kind_r <= in_payload_byte;
                if (((in_payload_byte == TypeNameFull) ||
                     (in_payload_byte == TypeNameShort)) && !ntaken_r) nlen_r <= '0;
                ph_r <= P_VAL;
                if (npos == send_r) done_s = 1'b1;
              end
              P_VAL: begin
                if (kind_r == TypeTxPower && vcnt0_r) pend_r <= in_payload_byte;
                else if (is_name && !ntaken_r && nlen_r < NameW'(NameLen - 1)) begin
                  name_r[nlen_r] <= in_payload_byte;
                  nlen_r <= nlen_r + 1'b1;
                end
                vcnt0_r <= 1'b0;
                if (npos == send_r) done_s = 1'b1;
              end
              default: ;
            endcase
            if (done_s) begin
              ph_r <= P_LEN;
              if (flen_r >= 8'd2) begin
                if (kind_r == TypeTxPower) begin
                  chosen_r <= (ph_r == P_VAL && vcnt0_r) ? in_payload_byte : pend_r;
                  pfound_r <= 1'b1;
                end else if (is_name) ntaken_r <= 1'b1;
              end
            end
          end
          if (req.start) begin
            rssi_r <= in_rssi;
            md_r <= M_SEARCH;
          end
        end
        M_SEARCH: if (rsp.done) begin
          // The last payload byte has been absorbed; resolve power and distance.
          pwr_r <= pfound_r ? chosen_r : dflt_r;
          pw = 10'(signed'(pfound_r ? chosen_r : dflt_r));
          rs = 10'(rssi_r);
          dist_r <= dist_of(pw - rs);
          near_r <= (rs >= pw - signed'(10'(loss2_r)));
          full_r <= rsp.full;
          slot_r <= rsp.slot;
          k_r <= '0;
          out_valid <= 1'b1;
          md_r <= M_EMIT;
        end
        M_EMIT: if (out_valid && !out_stall) begin
          if (full_r || k_r == NameW'(NameLen - 2)) begin
            out_valid <= 1'b0;
            md_r <= M_PARSE;
            ph_r <= P_LEN;
            pos_r <= '0; send_r <= '0; kind_r <= '0; pend_r <= '0; chosen_r <= '0;
            flen_r <= '0; halted_r <= 1'b0; pfound_r <= 1'b0; ntaken_r <= 1'b0;
            vcnt0_r <= 1'b1; nlen_r <= '0;
            for (int i = 0; i < NameLen - 1; i++) name_r[i] <= '0;
          end else k_r <= k_r + 1'b1;
        end
        default: md_r <= M_PARSE;
      endcase
    end
  end

  always_comb begin
    out_status = full_r;
    out_slot = full_r ? 4'd0 : 4'(slot_r);
    out_power_used = full_r ? 8'sd0 : pwr_r;
    out_distance_cm = full_r ? 11'd0 : dist_r;
    out_near = full_r ? 1'b0 : near_r;
    out_char_index = full_r ? 4'd0 : 4'(k_r);
    out_name_char = (!full_r && ntaken_r && k_r < nlen_r) ? name_r[k_r[NameW-1:0]] : 8'd0;
    out_run_last = full_r || (k_r == NameW'(NameLen - 2));
  end

`ifndef SYNTHESIS
  a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while emitting");
  a_full_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && full_r && !out_stall) |=> !out_valid) else $error("full run too long");
  a_nlen: assert property (@(posedge clk) disable iff (!rst_n)
    nlen_r <= NameW'(NameLen - 1)) else $error("name length overflow");
`endif
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import bart_pkg::*;

  // One payload item as the sender offers it.
  typedef struct packed {
    logic [47:0] addr;
    logic [7:0]  atype;
    logic [7:0]  rssi;
    logic [7:0]  pbyte;
    logic        bvalid;
    logic        blast;
  } adv_item_t;

  // One result item of an advertisement run.
  typedef struct packed {
    logic        status;
    logic [3:0]  slot;
    logic [7:0]  power;
    logic [10:0] dist_cm;
    logic        near;
    logic [3:0]  idx;
    logic [7:0]  ch;
    logic        last;
  } range_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [47:0] in_peer_address;
  logic [7:0] in_peer_address_type;
  logic signed [7:0] in_rssi;
  logic [7:0] in_payload_byte;
  logic in_byte_valid;
  logic in_last_byte;
  logic out_valid;
  logic out_stall;
  logic out_status;
  logic [3:0] out_slot;
  logic signed [7:0] out_power_used;
  logic [10:0] out_distance_cm;
  logic out_near;
  logic [3:0] out_char_index;
  logic [7:0] out_name_char;
  logic out_run_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;

  ble_adv_range_tracker_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_peer_address(in_peer_address), .in_peer_address_type(in_peer_address_type),
    .in_rssi(in_rssi), .in_payload_byte(in_payload_byte),
    .in_byte_valid(in_byte_valid), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_slot(out_slot), .out_power_used(out_power_used),
    .out_distance_cm(out_distance_cm), .out_near(out_near),
    .out_char_index(out_char_index), .out_name_char(out_name_char),
    .out_run_last(out_run_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Expected result items, oldest first.
  range_res_t range_q[$];
  int mismatches = 0;
  bit quiet = 0;          // no idling on either side in the final stretch
  bit hold_req = 0;       // asks the receiver for one long hold-off
  int send_idle_pct = 0;

  // Shadow copy of the block: registers, device table and parse state.
  logic signed [7:0] def_power;
  logic [7:0] loss_2m;
  int dev_count;
  logic [55:0] dev_keys[MaxDevices];
  int pos, struct_end, field_len, value_cnt, parse_step, name_len;
  logic [7:0] struct_type, pend_power, tx_power;
  bit halted, have_power, have_name;
  logic [7:0] name_buf[NameLen-1];
  range_res_t first_res;

  function automatic bit is_name(input logic [7:0] t);
    return t == TypeNameFull || t == TypeNameShort;
  endfunction

  function automatic void clear_parse();
    pos = 0; struct_end = 0; field_len = 0; value_cnt = 0; parse_step = 0;
    name_len = 0; struct_type = '0; pend_power = '0; tx_power = '0;
    halted = 0; have_power = 0; have_name = 0;
    foreach (name_buf[i]) name_buf[i] = 8'h00;
  endfunction

  // Walks one payload byte through the length-type-value parser.
  function automatic void parse_byte(input logic [7:0] b);
    int here;
    if (halted || pos >= 256) return;
    here = pos;
    pos = pos + 1;
    if (parse_step == 0) begin
      // A zero length byte ends parsing of this advertisement.
      if (b == 0) begin
        halted = 1;
        return;
      end
      field_len = int'(b);
      struct_end = here + int'(b) + 1;
      value_cnt = 0;
      parse_step = 1;
    end else if (parse_step == 1) begin
      struct_type = b;
      if (is_name(b) && !have_name) name_len = 0;
      parse_step = 2;
    end else begin
      if (struct_type == TypeTxPower && value_cnt == 0) pend_power = b;
      else if (is_name(struct_type) && !have_name && name_len < NameLen - 1) begin
        name_buf[name_len] = b;
        name_len++;
      end
      value_cnt++;
    end
    // A structure counts only once its last byte has arrived.
    if (parse_step == 2 && pos == struct_end) begin
      if (field_len >= 2) begin
        if (struct_type == TypeTxPower) begin
          tx_power = pend_power;
          have_power = 1;
        end else if (is_name(struct_type)) begin
          have_name = 1;
        end
      end
      parse_step = 0;
    end
  endfunction

  // Predicts the result items one accepted payload item causes.
  function automatic int predict_ranges(input adv_item_t it);
    logic [55:0] key;
    int slot, pw, rs, loss, n;
    bit hit;
    range_res_t r;
    if (it.bvalid) parse_byte(it.pbyte);
    if (!it.blast) return 0;
    key = {it.atype, it.addr};
    hit = 0;
    slot = 0;
    for (int i = 0; i < dev_count; i++) begin
      if (!hit && dev_keys[i] == key) begin
        slot = i;
        hit = 1;
      end
    end
    if (!hit) begin
      if (dev_count < MaxDevices) begin
        slot = dev_count;
        dev_keys[slot] = key;
        dev_count++;
      end else begin
        // Table full: one status item, nothing stored.
        r = '0;
        r.status = 1;
        r.last = 1;
        range_q.push_back(r);
        first_res = r;
        clear_parse();
        return 1;
      end
    end
    pw = have_power ? int'($signed(tx_power)) : int'(def_power);
    rs = int'($signed(it.rssi));
    loss = pw - rs;
    n = 0;
    for (int k = 0; k < NameLen - 1; k++) begin
      r.status = 0;
      r.slot = slot[3:0];
      r.power = pw[7:0];
      if (loss <= 0) r.dist_cm = 11'd100;
      else if (loss <= 6) r.dist_cm = 11'd201;
      else if (loss <= 10) r.dist_cm = 11'd316;
      else if (loss <= 14) r.dist_cm = 11'd500;
      else if (loss <= 20) r.dist_cm = 11'd1000;
      else r.dist_cm = 11'd2000;
      r.near = (rs >= pw - int'(loss_2m));
      r.idx = k[3:0];
      r.ch = (have_name && k < name_len) ? name_buf[k] : 8'h00;
      r.last = (k == NameLen - 2);
      range_q.push_back(r);
      if (k == 0) first_res = r;
      n++;
    end
    clear_parse();
    return n;
  endfunction

  // Clock.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Offers one item, optionally after a random gap, and waits until it is taken.
  task automatic offer_item(input adv_item_t it, output int nres);
    if (!quiet && send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_peer_address <= it.addr;
    in_peer_address_type <= it.atype;
    in_rssi <= it.rssi;
    in_payload_byte <= it.pbyte;
    in_byte_valid <= it.bvalid;
    in_last_byte <= it.blast;
    do @(posedge clk); while (!(in_valid && !in_stall));
    nres = predict_ranges(it);
  endtask

  // Waits until every expected item has come, then lets the table search settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (range_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after its last write.
  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == RegDefaultPower) def_power = val;
    else loss_2m = val;
  endtask

  // Small pool of advertisers so that slots get matched again and the table fills.
  logic [55:0] peer_pool[22];

  // Builds one advertisement and sends it.
  task automatic send_advert(input int min_len);
    logic [7:0] bytes[$];
    logic [55:0] key;
    adv_item_t it;
    int style, tgt, kind, n, nres;
    bit tail_item;
    key = ($urandom_range(0, 6) == 0) ? 56'({$urandom(), $urandom()}) :
          peer_pool[$urandom_range(0, 21)];
    style = $urandom_range(0, 11);
    tgt = (min_len > 0) ? min_len : $urandom_range(3, 15);
    if (style == 0) begin
      tgt = 0;                                  // empty payload
    end else if (style == 1) begin
      repeat (tgt) bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      while (bytes.size() < tgt) begin
        kind = $urandom_range(0, 5);
        if ($urandom_range(0, 24) == 0) begin
          bytes.push_back(8'h00);
          break;
        end
        case (kind)
          0, 1: begin
            n = (kind == 0) ? 1 : $urandom_range(0, 3);
            bytes.push_back(8'(n + 1));
            bytes.push_back(TypeTxPower);
            repeat (n) bytes.push_back(8'($urandom_range(0, 255)));
          end
          2, 3: begin
            n = $urandom_range(0, 20);
            bytes.push_back(8'(n + 1));
            bytes.push_back(kind == 2 ? TypeNameFull : TypeNameShort);
            repeat (n) bytes.push_back(8'($urandom_range(32, 255)));
          end
          default: begin
            n = (min_len > 0) ? $urandom_range(100, 254) : $urandom_range(0, 6);
            bytes.push_back(8'(n + 1));
            bytes.push_back(8'($urandom_range(0, 255)));
            repeat (n) bytes.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
      // Cut the last structure short now and then.
      if (style == 2 && bytes.size() > 3)
        repeat ($urandom_range(1, 2)) void'(bytes.pop_back());
    end
    tail_item = (bytes.size() == 0) || $urandom_range(0, 3) == 0;
    foreach (bytes[i]) begin
      if ($urandom_range(0, 15) == 0) begin
        // An item with no byte in the middle of the payload.
        it = {48'({$urandom(), $urandom()}), 8'($urandom()), 8'($urandom()),
              8'($urandom()), 1'b0, 1'b0};
        offer_item(it, nres);
      end
      it.addr = 48'({$urandom(), $urandom()});
      it.atype = 8'($urandom());
      it.rssi = 8'($urandom());
      it.pbyte = bytes[i];
      it.bvalid = 1'b1;
      it.blast = (i == bytes.size() - 1) && !tail_item;
      if (it.blast) {it.atype, it.addr} = key;
      offer_item(it, nres);
    end
    if (tail_item) begin
      it = {key[47:0], key[55:48], 8'($urandom()), 8'($urandom()), 1'b0, 1'b1};
      offer_item(it, nres);
    end
  endtask

  // Directed rows: the typed columns give power and distance of the run
  // where they are plain from the parse rules.
  localparam int DirRows = 21;
  adv_item_t dir_tab[DirRows];
  bit dir_typed[DirRows];
  logic [7:0] dir_power[DirRows];
  logic [10:0] dir_dist[DirRows];

  function automatic adv_item_t row(input logic [47:0] a, input logic [7:0] t,
                                    input logic [7:0] r, input logic [7:0] b,
                                    input logic v, input logic l);
    return {a, t, r, b, v, l};
  endfunction

  initial begin
    foreach (dir_typed[i]) dir_typed[i] = 0;
    // Empty payload at default power 0 and rssi 0: zero loss, nearest step.
    dir_tab[0] = row(48'h0000_1234_5678, 8'h01, 8'h00, 8'h55, 1'b0, 1'b1);
    dir_typed[0] = 1; dir_power[0] = 8'h00; dir_dist[0] = 11'd100;
    // An item without a byte and not the last one causes nothing.
    dir_tab[1] = row(48'h0, 8'h0, 8'h00, 8'hAA, 1'b0, 1'b0);
    // TX power -8, a full name "abc", then a zero length that halts parsing.
    dir_tab[2] = row(48'h0, 8'h0, 8'h00, 8'h02, 1'b1, 1'b0);
    dir_tab[3] = row(48'h0, 8'h0, 8'h00, TypeTxPower, 1'b1, 1'b0);
    dir_tab[4] = row(48'h0, 8'h0, 8'h00, 8'hF8, 1'b1, 1'b0);
    dir_tab[5] = row(48'h0, 8'h0, 8'h00, 8'h04, 1'b1, 1'b0);
    dir_tab[6] = row(48'h0, 8'h0, 8'h00, TypeNameFull, 1'b1, 1'b0);
    dir_tab[7] = row(48'h0, 8'h0, 8'h00, 8'h61, 1'b1, 1'b0);
    dir_tab[8] = row(48'h0, 8'h0, 8'h00, 8'h62, 1'b1, 1'b0);
    dir_tab[9] = row(48'h0, 8'h0, 8'h00, 8'h63, 1'b1, 1'b0);
    dir_tab[10] = row(48'hFFFF_FFFF_FFFF, 8'hFF, 8'h80, 8'h00, 1'b1, 1'b1);
    dir_typed[10] = 1; dir_power[10] = 8'hF8; dir_dist[10] = 11'd2000;
    // A short name cut off by the end of the payload is dropped.
    dir_tab[11] = row(48'h0, 8'h0, 8'h00, 8'h03, 1'b1, 1'b0);
    dir_tab[12] = row(48'h0, 8'h0, 8'h00, TypeNameShort, 1'b1, 1'b0);
    dir_tab[13] = row(48'h0000_1234_5678, 8'h01, 8'h7F, 8'h41, 1'b1, 1'b1);
    dir_typed[13] = 1; dir_power[13] = 8'h00; dir_dist[13] = 11'd100;
    // Two TX-power structures: the later one (-128) wins.
    dir_tab[14] = row(48'h0, 8'h0, 8'h00, 8'h02, 1'b1, 1'b0);
    dir_tab[15] = row(48'h0, 8'h0, 8'h00, TypeTxPower, 1'b1, 1'b0);
    dir_tab[16] = row(48'h0, 8'h0, 8'h00, 8'h7F, 1'b1, 1'b0);
    dir_tab[17] = row(48'h0, 8'h0, 8'h00, 8'h02, 1'b1, 1'b0);
    dir_tab[18] = row(48'h0, 8'h0, 8'h00, TypeTxPower, 1'b1, 1'b0);
    dir_tab[19] = row(48'h0, 8'h0, 8'h00, 8'h80, 1'b1, 1'b0);
    dir_tab[20] = row(48'h0, 8'h0, 8'h7F, 8'h00, 1'b0, 1'b1);
    dir_typed[20] = 1; dir_power[20] = 8'h80; dir_dist[20] = 11'd100;
  end

  // Main sequence: reset, directed rows, then random phases under several settings.
  initial begin
    int nres;
    in_valid = 0;
    in_peer_address = '0;
    in_peer_address_type = '0;
    in_rssi = '0;
    in_payload_byte = '0;
    in_byte_valid = 0;
    in_last_byte = 0;
    cfg_valid = 0;
    cfg_index = RegDefaultPower;
    cfg_data = '0;
    rst_n = 0;
    def_power = 8'sd0;
    loss_2m = 8'd46;
    dev_count = 0;
    clear_parse();
    foreach (peer_pool[i]) peer_pool[i] = 56'({$urandom(), $urandom()});
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    for (int i = 0; i < DirRows; i++) begin
      offer_item(dir_tab[i], nres);
      if (dir_typed[i] && (nres == 0 || first_res.power != dir_power[i] ||
                           first_res.dist_cm != dir_dist[i])) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: typed power %0d dist %0d, parse gives %0d %0d", i,
                   $signed(dir_power[i]), dir_dist[i], $signed(first_res.power),
                   first_res.dist_cm);
      end
    end
    drain_results();

    // Four random phases, each under its own register setting; the extremes come first.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(RegDefaultPower, 8'h80);
          write_reg(RegLossTwoM, 8'h00);
        end
        1: begin
          write_reg(RegDefaultPower, 8'h7F);
          write_reg(RegLossTwoM, 8'hFF);
        end
        default: begin
          write_reg(RegDefaultPower, 8'($urandom_range(0, 255)));
          write_reg(RegLossTwoM, 8'($urandom_range(0, 60)));
        end
      endcase
      cfg_valid <= 1'b0;
      // The long receiver hold-off falls in the second phase, with the sender still busy.
      if (ph == 1) hold_req = 1;
      if (ph == 3) quiet = 1;
      for (int a = 0; a < 4; a++) begin
        send_idle_pct = (a % 3 == 0) ? 0 : $urandom_range(5, 40);
        send_advert(0);
      end
      drain_results();
    end

    // Every expected item is in; wait out the block's own latency.
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: each accepted item against the oldest expectation.
  always @(posedge clk) begin
    range_res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_slot, out_power_used, out_distance_cm, out_near,
             out_char_index, out_name_char, out_run_last};
      if (range_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with nothing expected: %h", got);
      end else begin
        want = range_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: exp st %0d slot %0d pw %0d dist %0d near %0d ",
                      "idx %0d ch %h last %0d / got st %0d slot %0d pw %0d dist %0d ",
                      "near %0d idx %0d ch %h last %0d"},
                     want.status, want.slot, $signed(want.power), want.dist_cm, want.near,
                     want.idx, want.ch, want.last, got.status, got.slot,
                     $signed(got.power), got.dist_cm, got.near, got.idx, got.ch, got.last);
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no item moving on any channel.
  int still_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
        !rst_n) begin
      still_cycles <= 0;
    end else if (still_cycles >= 3000) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      still_cycles <= still_cycles + 1;
    end
  end
endmodule
`default_nettype wire

// ===== sim.f =====
design/bart_pkg.sv
design/bart_ram.sv
design/bart_search.sv
design/ble_adv_range_tracker_core.sv
bench/tb.sv
